@@ sv/sccb_pkg.sv @@
// ----------------------------------------------------------------------------
// sccb_pkg: shared types and constants for the solid color coverage blend
// Widths, register map codes, opacity scaling table, pipeline enable bundle.
// ----------------------------------------------------------------------------
package sccb_pkg;

  localparam int CHAN_W       = 8;
  localparam int NUM_LANES    = 4;
  localparam int ALPHA_LEVELS = 256;
  localparam int ALPHA_SHIFT  = 6;
  localparam int ALPHA_MUL    = 505;
  localparam int ALPHA_DIV    = 1000;
  localparam int DIFF_SHIFT   = 2;
  localparam int SCALE_W      = 15;   // scaled opacity, max 16448
  localparam int WEIGHT_W     = 14;   // per-pixel weight, max 16383
  localparam int DIFF_W       = 11;   // (d - c) << 2, signed
  localparam int PROD_W       = DIFF_W + WEIGHT_W + 1;
  localparam int PROD_SHIFT   = 16;
  localparam int RES_W        = PROD_W - PROD_SHIFT;  // signed quotient
  localparam int SUM_W        = 11;   // d - q, signed

  localparam logic [7:0] ALPHA_RESET = 8'hFF;

  // Register map, decoded on paddr[2]
  typedef enum logic {
    REG_COLOR = 1'b0,
    REG_ALPHA = 1'b1
  } reg_sel_t;

  typedef logic [SCALE_W-1:0] scale_tab_t [ALPHA_LEVELS];

  // s = (a << 6) + floor(505 * a / 1000), built at elaboration
  function automatic scale_tab_t build_scale_tab();
    scale_tab_t tab;
    for (int i = 0; i < ALPHA_LEVELS; i++) begin
      tab[i] = SCALE_W'((i << ALPHA_SHIFT) + (ALPHA_MUL * i) / ALPHA_DIV);
    end
    return tab;
  endfunction

  localparam scale_tab_t SCALE_TAB = build_scale_tab();

  // Per-stage load enables of the blend pipeline
  typedef struct packed {
    logic en2;
    logic en3;
    logic en4;
  } pipe_en_t;

endpackage

@@ sv/sccb_weight.sv @@
// ----------------------------------------------------------------------------
// sccb_weight: per-pixel blend weight
// w = (coverage * s) >> 8, registered; shared by all channel lanes.
// ----------------------------------------------------------------------------
module sccb_weight import sccb_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [CHAN_W-1:0]   coverage,
  input  logic [SCALE_W-1:0]  scale,
  output logic [WEIGHT_W-1:0] weight
);

  logic [CHAN_W+SCALE_W-1:0] prod;
  logic [WEIGHT_W-1:0]       weight_r;

  assign prod   = {{SCALE_W{1'b0}}, coverage} * {{CHAN_W{1'b0}}, scale};
  assign weight = weight_r;

  always_ff @(posedge clk) begin
    if (en) begin
      weight_r <= prod[CHAN_W +: WEIGHT_W];
    end
  end

endmodule

@@ sv/sccb_lane.sv @@
// ----------------------------------------------------------------------------
// sccb_lane: one channel of the blend
// Difference, signed product with the weight, floor shift, subtract, clamp.
// ----------------------------------------------------------------------------
module sccb_lane import sccb_pkg::*; (
  input  logic                clk,
  input  pipe_en_t            pen,
  input  logic [CHAN_W-1:0]   dst,
  input  logic [CHAN_W-1:0]   color,
  input  logic [WEIGHT_W-1:0] weight,
  output logic [CHAN_W-1:0]   result
);

  logic signed [DIFF_W-1:0] diff4_r, diff4_nxt;
  logic [CHAN_W-1:0]        d2_r, d3_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [RES_W-1:0]  quot;
  logic signed [SUM_W-1:0]  sum;

  assign diff4_nxt = ($signed({{(DIFF_W-CHAN_W){1'b0}}, dst})
                    - $signed({{(DIFF_W-CHAN_W){1'b0}}, color})) <<< DIFF_SHIFT;

  always_ff @(posedge clk) begin
    if (pen.en2) begin
      diff4_r <= diff4_nxt;
      d2_r    <= dst;
    end
    if (pen.en3) begin
      prod_r <= PROD_W'(diff4_r) * $signed({1'b0, weight});
      d3_r   <= d2_r;
    end
  end

  // Arithmetic shift gives the floor
  assign quot = prod_r[PROD_W-1:PROD_SHIFT];
  assign sum  = $signed({{(SUM_W-CHAN_W){1'b0}}, d3_r})
              - $signed({{(SUM_W-RES_W){quot[RES_W-1]}}, quot});

  always_comb begin
    if (sum < 0) begin
      result = '0;
    end else if (sum > $signed(SUM_W'(255))) begin
      result = '1;
    end else begin
      result = sum[CHAN_W-1:0];
    end
  end

endmodule

@@ sv/solid_color_coverage_blend.sv @@
// ----------------------------------------------------------------------------
// solid_color_coverage_blend: blend pixels toward a solid color by coverage
// Four channel lanes behind a shared weight unit, merged into one result.
// ----------------------------------------------------------------------------
// Each input transaction carries one destination pixel (four bytes) and a
// coverage byte; each output transaction carries the blended pixel. The
// block takes one transaction per clock while the output is not stalled,
// set by a fully pipelined datapath in which no item holds a shared unit
// past its own stage. There are four register stages: input register,
// weight multiply (coverage times scaled opacity) alongside the per-lane
// color difference, lane product, then clamp into the output register. The
// accepting edge sets v1_r, and the valid bit then moves through v2_r and
// v3_r into out_valid_r, which drives out_tvalid. Every stage has its own
// valid bit and loads whenever it is empty or its successor moves, so
// bubbles close up and input keeps flowing into empty stages while a
// result waits on the output. The opacity is scaled through a constant
// table when fill_alpha is written, so a pixel never sees the scaling
// arithmetic. Registers: 0x0 fill_color (byte k is the color for pixel
// byte k, reset 0), 0x4 fill_alpha (low 8 bits, reset 0xFF). Write
// registers only with no transaction in flight.
// ----------------------------------------------------------------------------
module solid_color_coverage_blend import sccb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // chan0_in, chan1_in, chan2_in, chan3_in, coverage
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // chan0_out, chan1_out, chan2_out, chan3_out
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // --- configuration registers ---
  logic [31:0]        color_r;
  logic [7:0]         alpha_r;
  logic [SCALE_W-1:0] scale_r;   // table lookup of alpha_r, kept in step
  logic               cfg_wr;
  reg_sel_t           cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel    = reg_sel_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= '0;
      alpha_r <= ALPHA_RESET;
      scale_r <= SCALE_TAB[ALPHA_RESET];
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_COLOR: color_r <= cfg_pwdata;
        REG_ALPHA: begin
          alpha_r <= cfg_pwdata[7:0];
          scale_r <= SCALE_TAB[cfg_pwdata[7:0]];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_COLOR: cfg_prdata = color_r;
      REG_ALPHA: cfg_prdata = {24'b0, alpha_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // --- pipeline flow control ---
  logic     v1_r, v2_r, v3_r, out_valid_r;
  logic     adv1, adv2, adv3, adv4;
  pipe_en_t pen;

  assign adv4 = !out_valid_r || out_tready;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;

  assign pen.en2 = adv2;
  assign pen.en3 = adv3;
  assign pen.en4 = adv4;

  assign in_tready  = adv1;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) v1_r        <= in_tvalid;
      if (adv2) v2_r        <= v1_r;
      if (adv3) v3_r        <= v2_r;
      if (adv4) out_valid_r <= v3_r;
    end
  end

  // --- stage 1: input register ---
  logic [CHAN_W-1:0] dst_r [NUM_LANES];
  logic [CHAN_W-1:0] cov_r;

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        dst_r[k] <= in_tdata[k*CHAN_W +: CHAN_W];
      end
      cov_r <= in_tdata[NUM_LANES*CHAN_W +: CHAN_W];
    end
  end

  // --- stage 2: weight, shared by the lanes ---
  logic [WEIGHT_W-1:0] weight;

  sccb_weight u_weight (
    .clk      (clk),
    .en       (pen.en2),
    .coverage (cov_r),
    .scale    (scale_r),
    .weight   (weight)
  );

  // --- stages 2..3: channel lanes ---
  logic [CHAN_W-1:0] lane_res [NUM_LANES];

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    sccb_lane u_lane (
      .clk    (clk),
      .pen    (pen),
      .dst    (dst_r[g]),
      .color  (color_r[g*CHAN_W +: CHAN_W]),
      .weight (weight),
      .result (lane_res[g])
    );
  end

  // --- stage 4: merge lanes into the output register ---
  logic [31:0] out_data_r;

  always_ff @(posedge clk) begin
    if (pen.en4) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        out_data_r[k*CHAN_W +: CHAN_W] <= lane_res[k];
      end
    end
  end

  assign out_tdata = out_data_r;

endmodule
